// File: hw/rtl/tbmi_pkg.sv
// Package with the types and constants of the TS block marker inserter.
`default_nettype none

package tbmi_pkg;

  localparam int unsigned INTERVAL_W = 12;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned SSRC_W     = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WIDX_W     = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CC_W       = 4;
  localparam int unsigned MARK_W     = 32;

  // Bytes 0..27 of the marker packet go out one byte per cycle while no finished word waits on a stalled output.
  localparam int unsigned SERIAL_BYTES = 28;
  localparam int unsigned BCNT_W       = 5;
  localparam int unsigned SR_W         = SERIAL_BYTES * BYTE_W;

  localparam logic [BCNT_W-1:0] LAST_SERIAL_BYTE   = BCNT_W'(SERIAL_BYTES - 1);
  localparam logic [BCNT_W-1:0] SECTION_FIRST_BYTE = BCNT_W'(5);

  localparam logic [WIDX_W-1:0] CRC_WORD_IDX   = WIDX_W'(7);
  localparam logic [WIDX_W-1:0] FIRST_FILL_IDX = WIDX_W'(8);
  localparam logic [WIDX_W-1:0] LAST_WORD_IDX  = WIDX_W'(46);

  localparam logic [WORD_W-1:0] FILL_WORD = 32'hFFFF_FFFF;

  localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL = 12'd5;

  localparam logic [BYTE_W-1:0] MARKER_SYNC   = 8'h47;
  localparam logic [BYTE_W-1:0] TS_PID_HI     = 8'h5F;  // PUSI set, PID 0x1FF0
  localparam logic [BYTE_W-1:0] TS_PID_LO     = 8'hF0;
  localparam logic [3:0]        TS_AFC_PAYLOAD = 4'h1;
  localparam logic [BYTE_W-1:0] PTR_ZERO      = 8'h00;
  localparam logic [BYTE_W-1:0] TABLE_ID      = 8'hBF;
  localparam logic [15:0]       SECTION_HDR   = 16'h3018; // 3 << 12 | length 24

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERIAL,
    ST_CRC,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic init;
    logic update;
  } crc_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/tbmi_if.sv
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none

interface tbmi_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_seq;
  logic [31:0] stream_ssrc;
  logic        payload_complete;

  modport source (output valid, output packet_seq, output stream_ssrc,
                  output payload_complete, input ready);
  modport sink   (input valid, input packet_seq, input stream_ssrc,
                  input payload_complete, output ready);
endinterface

interface tbmi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] marker_word;
  logic [5:0]  word_index;
  logic        last_word;

  modport source (output valid, output marker_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input marker_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tbmi_crc.sv
// Byte-wise CRC-32/MPEG-2 register for the marker section.
`default_nettype none

module tbmi_crc
  import tbmi_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire crc_ctl_t          ctl_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output      logic [31:0]       crc_o
);

  logic [31:0] crc_q, crc_d, step;

  always_comb begin
    step = crc_q ^ {byte_i, 24'h0};
    for (int b = 0; b < BYTE_W; b++) begin
      step = step[31] ? ((step << 1) ^ CRC_POLY) : (step << 1);
    end
    crc_d = crc_q;
    if (ctl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctl_i.update) begin
      crc_d = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

// File: hw/rtl/ts_block_marker_inserter_top.sv
// Top level of the TS block marker inserter.
`default_nettype none

// Each input transaction is one parsed RTP packet. The block counts packets
// whose payload is complete; when the count already equals the interval as
// a packet arrives, it first emits a 188-byte TS marker packet (PID 0x1FF0)
// as 47 big-endian 32-bit result transactions, word_index 0 to 46 with
// last_word on the final one, and then opens a new block at the arriving
// packet. A packet that triggers no marker is simply taken. A packet that
// triggers a marker is taken and then holds the input off while the marker
// is produced: the first 28 packet bytes leave a byte-wide shift register one
// per cycle while the section CRC is updated one byte per cycle, then the CRC
// word and 39 fill words of 0xFF follow. A result stall lengthens that only
// while a word waits in the output register that the sequencer must replace:
// each stalled cycle counts during the CRC and fill words, while during the
// 28 serial bytes a stall is absorbed until the next word is complete. The
// input is ready again as soon as the last word sits in the output register,
// so the next packet can be accepted while that word still waits to be
// taken. The interval is to be written through cfg_we_i/cfg_data_i only
// while the block is idle; the block itself does not enforce this. A write
// of zero selects the default interval of five.

module ts_block_marker_inserter_top
  import tbmi_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [INTERVAL_W-1:0] cfg_data_i,
  tbmi_in_if.sink                    in_i,
  tbmi_out_if.source                 out_o
);

  // Block bookkeeping.
  logic [INTERVAL_W-1:0] interval_q;
  logic [INTERVAL_W-1:0] count_q, count_d;
  logic [SEQ_W-1:0]      start_seq_q, start_seq_d;
  logic [MARK_W-1:0]     marker_num_q;
  logic [CC_W-1:0]       cc_q;

  // Marker generation.
  state_e              state_q, state_d;
  logic [SR_W-1:0]     sr_q;
  logic [BCNT_W-1:0]   byte_cnt_q;
  logic [WIDX_W-1:0]   word_cnt_q;
  logic [23:0]         wacc_q;
  logic [BYTE_W-1:0]   cur_byte;
  logic [31:0]         crc;
  crc_ctl_t            crc_ctl;

  // Output register.
  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic [WIDX_W-1:0] out_idx_q;
  logic              out_last_q;

  logic              in_fire, marker_due, can_push, advance, push, push_last;
  logic [WORD_W-1:0] push_word;
  logic [WIDX_W-1:0] push_idx;
  logic [SEQ_W-1:0]  nonnull_cnt, next_seq;

  assign in_fire    = in_i.valid && in_i.ready;
  assign marker_due = (count_q == interval_q);
  assign can_push   = !out_valid_q || out_o.ready;
  assign cur_byte   = sr_q[SR_W-1 -: BYTE_W];

  // Interval times seven, and the sequence number that follows the block.
  assign nonnull_cnt = SEQ_W'({interval_q, 3'b000}) - SEQ_W'(interval_q);
  assign next_seq    = start_seq_q + SEQ_W'(count_q);

  always_comb begin
    count_d     = marker_due ? '0 : count_q;
    count_d     = count_d + INTERVAL_W'(in_i.payload_complete);
    start_seq_d = (marker_due || count_q == '0) ? in_i.packet_seq : start_seq_q;
  end

  // Sequencer: next state and per-cycle controls.
  always_comb begin
    state_d        = state_q;
    advance        = 1'b0;
    push           = 1'b0;
    push_word      = FILL_WORD;
    push_idx       = word_cnt_q;
    push_last      = 1'b0;
    crc_ctl.init   = 1'b0;
    crc_ctl.update = 1'b0;
    in_i.ready     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && marker_due) begin
          crc_ctl.init = 1'b1;
          state_d      = ST_SERIAL;
        end
      end
      ST_SERIAL: begin
        advance        = (byte_cnt_q[1:0] != 2'd3) || can_push;
        push           = advance && (byte_cnt_q[1:0] == 2'd3);
        push_word      = {wacc_q, cur_byte};
        push_idx       = WIDX_W'(byte_cnt_q[BCNT_W-1:2]);
        crc_ctl.update = advance && (byte_cnt_q >= SECTION_FIRST_BYTE);
        if (advance && byte_cnt_q == LAST_SERIAL_BYTE) begin
          state_d = ST_CRC;
        end
      end
      ST_CRC: begin
        push      = can_push;
        push_word = crc;
        push_idx  = CRC_WORD_IDX;
        if (can_push) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        push      = can_push;
        push_last = (word_cnt_q == LAST_WORD_IDX);
        if (can_push && push_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Interval register, written on cfg_we_i, and block bookkeeping, updated at input acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= DEFAULT_INTERVAL;
      count_q      <= '0;
      start_seq_q  <= '0;
      marker_num_q <= '0;
      cc_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= (cfg_data_i == '0) ? DEFAULT_INTERVAL : cfg_data_i;
      end
      if (in_fire) begin
        count_q     <= count_d;
        start_seq_q <= start_seq_d;
        if (marker_due) begin
          marker_num_q <= marker_num_q + 1'b1;
          cc_q         <= cc_q + 1'b1;
        end
      end
    end
  end

  // Byte shift register: loaded with packet bytes 0..27 when a marker is due,
  // then shifted out one byte per cycle while the sequencer advances. The words are assembled in wacc_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      word_cnt_q <= '0;
    end else begin
      if (in_fire && marker_due) begin
        byte_cnt_q <= '0;
      end else if (advance) begin
        byte_cnt_q <= byte_cnt_q + 1'b1;
      end
      if (state_q == ST_CRC) begin
        word_cnt_q <= FIRST_FILL_IDX;
      end else if (state_q == ST_FILL && can_push) begin
        word_cnt_q <= word_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && marker_due) begin
      sr_q <= {MARKER_SYNC, TS_PID_HI, TS_PID_LO, {TS_AFC_PAYLOAD, cc_q},
               PTR_ZERO, TABLE_ID, SECTION_HDR,
               marker_num_q,
               nonnull_cnt, 16'h0000,
               16'h0000,
               start_seq_q, 16'h0000,
               next_seq,
               in_i.stream_ssrc};
    end else if (advance) begin
      sr_q   <= {sr_q[SR_W-BYTE_W-1:0], BYTE_W'(0)};
      wacc_q <= {wacc_q[15:0], cur_byte};
    end
  end

  // Output register, so the sequencer can move on while a word waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_word_q <= push_word;
      out_idx_q  <= push_idx;
      out_last_q <= push_last;
    end
  end

  tbmi_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .byte_i (cur_byte),
    .crc_o  (crc)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.marker_word = out_word_q;
  assign out_o.word_index  = out_idx_q;
  assign out_o.last_word   = out_last_q;

endmodule

`default_nettype wire
